[src/rotary_dial_digit_entry_core_macros.svh]
// Assertion macros used by the checker file of the dial digit entry core.
`ifndef ROTARY_DIAL_DIGIT_ENTRY_CORE_MACROS_SVH
`define ROTARY_DIAL_DIGIT_ENTRY_CORE_MACROS_SVH

// The consequent must hold on the same edge as the antecedent.
`define RDDE_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rdde check failed");

// The consequent must hold on the edge after the antecedent.
`define RDDE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rdde check failed");

`endif

[src/rdde_pkg.sv]
// Types and constants of the rotary dial digit entry core.
package rdde_pkg;

	localparam int unsigned TICK_W  = 16;
	localparam int unsigned PULSE_W = 5;

	localparam logic [TICK_W-1:0]  QUIET_MAX     = {TICK_W{1'b1}};
	localparam logic [PULSE_W-1:0] PULSE_MAX     = {PULSE_W{1'b1}};
	localparam logic [TICK_W-1:0]  FINISH_RESET  = 16'd100;
	localparam logic [TICK_W-1:0]  DEBOUNCE_RESET = 16'd10;
	localparam logic [3:0]         TENS_MAX      = 4'd5;

	// Configuration register indexes.
	localparam logic CFG_FINISH   = 1'b0;
	localparam logic CFG_DEBOUNCE = 1'b1;

	// Entry positions.
	localparam logic [1:0] POS_MIN_TENS = 2'd0;
	localparam logic [1:0] POS_SEC_TENS = 2'd2;
	localparam logic [1:0] POS_LAST     = 2'd3;

	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_ACCEPT = 2'd1,
		EV_REJECT = 2'd2
	} digit_event_t;

	typedef struct packed {
		digit_event_t digit_event;
		logic [3:0]   digit;
		logic [1:0]   position;
		logic         entry_done;
		logic [5:0]   minutes;
		logic [5:0]   seconds;
	} rdde_result_t;

	// Pulse count modulo ten; the count never exceeds 31.
	function automatic logic [3:0] mod10(input logic [PULSE_W-1:0] cnt);
		logic [PULSE_W-1:0] r;
		begin
			if (cnt >= 5'd30) begin
				r = cnt - 5'd30;
			end else if (cnt >= 5'd20) begin
				r = cnt - 5'd20;
			end else if (cnt >= 5'd10) begin
				r = cnt - 5'd10;
			end else begin
				r = cnt;
			end
			mod10 = r[3:0];
		end
	endfunction

	// Two decimal digits to a binary value below 100, kept to six bits.
	function automatic logic [5:0] two_digits(input logic [3:0] tens, input logic [3:0] ones);
		logic [6:0] v;
		begin
			v = ({3'd0, tens} << 3) + ({3'd0, tens} << 1) + {3'd0, ones};
			two_digits = v[5:0];
		end
	endfunction

endpackage

[src/rdde_tick.sv]
// Per-tick dial state: debounce, pulse count, digit close and entry assembly.
module rdde_tick (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic                         dial,
	input  logic                         hook,
	input  logic [rdde_pkg::TICK_W-1:0]  finish_ticks,
	input  logic [rdde_pkg::TICK_W-1:0]  debounce_ticks,
	output rdde_pkg::rdde_result_t       result
);
	import rdde_pkg::*;

	logic               last_raw_q;
	logic               stable_q;
	logic [TICK_W-1:0]  quiet_q;
	logic [PULSE_W-1:0] pulse_q;
	logic               pending_q;
	logic [1:0]         entry_pos_q;
	logic               on_hook_q;
	logic [3:0]         digits_q [3];

	logic               stable_d;
	logic [TICK_W-1:0]  quiet_inc;
	logic [TICK_W-1:0]  quiet_d;
	logic [PULSE_W-1:0] pulse_d;
	logic               pending_d;
	logic [1:0]         pos_lift;
	logic [1:0]         entry_pos_d;
	logic               on_hook_d;
	logic               finish;
	logic [3:0]         dval;
	logic               reject;
	logic               store_en;
	logic               debounce_hit;

	// Next state and the result for the item in the input register.
	always_comb begin
		quiet_inc = (quiet_q == QUIET_MAX) ? quiet_q : quiet_q + 1'b1;

		// Hook handling: a lift after hang-up restarts the entry.
		on_hook_d = on_hook_q;
		pos_lift  = entry_pos_q;
		if (!hook) begin
			on_hook_d = 1'b1;
		end else if (on_hook_q) begin
			on_hook_d = 1'b0;
			pos_lift  = POS_MIN_TENS;
		end

		// Digit close after a long enough quiet gap.
		finish      = (quiet_inc > finish_ticks) && pending_q;
		dval        = mod10(pulse_q);
		reject      = ((pos_lift == POS_MIN_TENS) || (pos_lift == POS_SEC_TENS))
		              && (dval > TENS_MAX);
		store_en    = 1'b0;
		entry_pos_d = pos_lift;
		pulse_d     = pulse_q;
		pending_d   = pending_q;
		result      = '0;
		if (finish) begin
			result.digit    = dval;
			result.position = pos_lift;
			pending_d       = 1'b0;
			pulse_d         = '0;
			if (reject) begin
				result.digit_event = EV_REJECT;
			end else begin
				result.digit_event = EV_ACCEPT;
				if (pos_lift != POS_LAST) begin
					store_en    = 1'b1;
					entry_pos_d = pos_lift + 1'b1;
				end else begin
					result.entry_done = 1'b1;
					result.minutes    = two_digits(digits_q[0], digits_q[1]);
					result.seconds    = two_digits(digits_q[2], dval);
					entry_pos_d       = POS_MIN_TENS;
				end
			end
		end

		// A raw change restarts the quiet count.
		quiet_d = (dial != last_raw_q) ? '0 : quiet_inc;

		// Debounced rising edges count only while lifted.
		debounce_hit = (quiet_d > debounce_ticks) && hook && (dial != stable_q);
		stable_d     = stable_q;
		if (debounce_hit) begin
			stable_d = dial;
			if (dial) begin
				if (pulse_d != PULSE_MAX) begin
					pulse_d = pulse_d + 1'b1;
				end
				pending_d = 1'b1;
			end
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q  <= 1'b0;
			stable_q    <= 1'b0;
			quiet_q     <= '0;
			pulse_q     <= '0;
			pending_q   <= 1'b0;
			entry_pos_q <= POS_MIN_TENS;
			on_hook_q   <= 1'b1;
		end else if (step) begin
			last_raw_q  <= dial;
			stable_q    <= stable_d;
			quiet_q     <= quiet_d;
			pulse_q     <= pulse_d;
			pending_q   <= pending_d;
			entry_pos_q <= entry_pos_d;
			on_hook_q   <= on_hook_d;
		end
	end

	// Digit store; each entry is written before it is read.
	always_ff @(posedge clk) begin
		if (step && store_en) begin
			digits_q[pos_lift] <= dval;
		end
	end

endmodule

[src/rotary_dial_digit_entry_core.sv]
// Rotary dial digit entry: one tick item in, one result item out.
// Each tick item passes through the input register, then the result register.
// Throughput: one item per cycle while out_stall does not hold the result; the tick update sets the rate.
// A result held under stall still lets one more item wait in the input register.
// Reset (asynchronous, active low) empties both registers, restores dial and
// entry state, and loads finish_ticks 100 and debounce_ticks 10.
module rotary_dial_digit_entry_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        dial_level,
	input  logic        hook_level,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  digit_event,
	output logic [3:0]  digit,
	output logic [1:0]  position,
	output logic        entry_done,
	output logic [5:0]  minutes,
	output logic [5:0]  seconds,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import rdde_pkg::*;

	logic              valid_s1;
	logic              dial_s1;
	logic              hook_s1;
	logic              advance;
	logic              in_take;
	logic [TICK_W-1:0] finish_q;
	logic [TICK_W-1:0] debounce_q;
	logic              out_valid_q;
	rdde_result_t      res_q;
	rdde_result_t      res_c;

	// Handshake: the input register moves on when the result register is free.
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_take   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			finish_q   <= FINISH_RESET;
			debounce_q <= DEBOUNCE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_FINISH:   finish_q   <= cfg_data;
				CFG_DEBOUNCE: debounce_q <= cfg_data;
				default:      finish_q   <= finish_q;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_take || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			dial_s1 <= dial_level;
			hook_s1 <= hook_level;
		end
	end

	rdde_tick u_tick (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.dial           (dial_s1),
		.hook           (hook_s1),
		.finish_ticks   (finish_q),
		.debounce_ticks (debounce_q),
		.result         (res_c)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_c;
		end
	end

	assign out_valid   = out_valid_q;
	assign digit_event = res_q.digit_event;
	assign digit       = res_q.digit;
	assign position    = res_q.position;
	assign entry_done  = res_q.entry_done;
	assign minutes     = res_q.minutes;
	assign seconds     = res_q.seconds;

endmodule

[src/rdde_checker.sv]
// Port-level checks of the dial digit entry core and their bind.
`include "rotary_dial_digit_entry_core_macros.svh"

module rdde_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] digit_event,
	input logic [3:0] digit,
	input logic [1:0] position,
	input logic       entry_done,
	input logic [5:0] minutes,
	input logic [5:0] seconds
);
	import rdde_pkg::*;

	logic quiet_fields_zero;
	logic entry_fields_ok;

	// Field summaries used by the checks below.
	assign quiet_fields_zero = (digit == 4'd0) && (position == 2'd0) && !entry_done
		&& (minutes == 6'd0) && (seconds == 6'd0);
	assign entry_fields_ok = (digit_event == EV_ACCEPT) && (position == POS_LAST)
		&& (minutes < 6'd60) && (seconds < 6'd60);

	// A stalled result stays offered.
	`RDDE_ASSERT_NEXT(a_hold_valid, out_valid && out_stall, out_valid)

	// A tick without a closed digit reports nothing else.
	`RDDE_ASSERT_SAME(a_quiet_tick, out_valid && (digit_event == EV_NONE), quiet_fields_zero)

	// A completed entry comes from an accepted last digit and holds a valid time.
	`RDDE_ASSERT_SAME(a_entry_done, out_valid && entry_done, entry_fields_ok)

	// Only a large digit at a tens position is rejected.
	`RDDE_ASSERT_SAME(a_reject, out_valid && (digit_event == EV_REJECT), (digit > TENS_MAX) && ((position == POS_MIN_TENS) || (position == POS_SEC_TENS)))

endmodule

bind rotary_dial_digit_entry_core rdde_checker u_rdde_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.digit_event (digit_event),
	.digit       (digit),
	.position    (position),
	.entry_done  (entry_done),
	.minutes     (minutes),
	.seconds     (seconds)
);

[sim/tb_top.sv]
// Self-checking testbench for the rotary dial digit entry core.
`timescale 1ns / 1ps

module tb_top;
	import rdde_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DIAL_BASE    = 10;

	typedef struct {
		bit dial;
		bit hook;
	} dial_tick_t;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic        in_stall;
	logic        dial_level = 1'b0;
	logic        hook_level = 1'b0;
	logic        out_valid;
	logic        out_stall  = 1'b0;
	logic [1:0]  digit_event;
	logic [3:0]  digit;
	logic [1:0]  position;
	logic        entry_done;
	logic [5:0]  minutes;
	logic [5:0]  seconds;
	logic        cfg_valid  = 1'b0;
	logic        cfg_ready;
	logic        cfg_index  = CFG_FINISH;
	logic [15:0] cfg_data   = '0;

	// Tick items waiting to be sent and tick results still to arrive.
	dial_tick_t   dial_ticks[$];
	rdde_result_t tick_results_due[$];
	dial_tick_t   next_tick;
	rdde_result_t due_result;
	int           ticks_made    = 0;
	int           mismatch_count = 0;
	int           cycle_count   = 0;
	int           send_idle_pct = 0;
	int           stall_pct     = 0;
	int           hold_arm      = 0;
	int           hold_seen     = 0;
	int           hold_left     = 0;

	// Predictor state and its copy of the registers.
	logic [15:0] finish_limit;
	logic [15:0] debounce_limit;
	logic        raw_prev;
	logic        level_kept;
	logic [15:0] quiet_cnt;
	logic [4:0]  pulse_cnt;
	logic        pend;
	logic [1:0]  pos_cnt;
	logic [3:0]  digit_store [0:2];
	logic        hook_down;

	rotary_dial_digit_entry_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.dial_level(dial_level), .hook_level(hook_level),
		.out_valid(out_valid), .out_stall(out_stall),
		.digit_event(digit_event), .digit(digit), .position(position),
		.entry_done(entry_done), .minutes(minutes), .seconds(seconds),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// One tick of the dial decoder: advances the state and returns the result item.
	function automatic rdde_result_t decode_tick(input bit dial, input bit lifted);
		rdde_result_t r;
		logic [3:0]   d;
		r = '0;
		r.digit_event = EV_NONE;
		if (quiet_cnt != QUIET_MAX) begin
			quiet_cnt = quiet_cnt + 1'b1;
		end
		// Lifting the handset after a hang-up starts a fresh entry.
		if (!lifted) begin
			hook_down = 1'b1;
		end else if (hook_down) begin
			hook_down = 1'b0;
			pos_cnt = POS_MIN_TENS;
			for (int i = 0; i < 3; i++) digit_store[i] = '0;
		end
		// Close the pending digit once the contact has been quiet long enough.
		if (quiet_cnt > finish_limit && pend) begin
			d = 4'(pulse_cnt % DIAL_BASE);
			r.digit = d;
			r.position = pos_cnt;
			if ((pos_cnt == POS_MIN_TENS || pos_cnt == POS_SEC_TENS) && d > TENS_MAX) begin
				r.digit_event = EV_REJECT;
			end else begin
				r.digit_event = EV_ACCEPT;
				if (pos_cnt != POS_LAST) begin
					digit_store[pos_cnt] = d;
					pos_cnt = pos_cnt + 1'b1;
				end else begin
					r.entry_done = 1'b1;
					r.minutes = 6'(digit_store[0] * DIAL_BASE + digit_store[1]);
					r.seconds = 6'(digit_store[2] * DIAL_BASE + d);
					for (int i = 0; i < 3; i++) digit_store[i] = '0;
					pos_cnt = POS_MIN_TENS;
				end
			end
			pend = 1'b0;
			pulse_cnt = '0;
		end
		if (dial != raw_prev) begin
			quiet_cnt = '0;
		end
		// Debounced rising edges count as pulses, but only off hook.
		if (quiet_cnt > debounce_limit && lifted && dial != level_kept) begin
			level_kept = dial;
			if (dial) begin
				if (pulse_cnt != PULSE_MAX) begin
					pulse_cnt = pulse_cnt + 1'b1;
				end
				pend = 1'b1;
			end
		end
		raw_prev = dial;
		return r;
	endfunction

	task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			mismatch_count++;
		end
	endtask

	task automatic put_ticks(input bit dial, input bit hook, input int reps);
		dial_tick_t t;
		t.dial = dial;
		t.hook = hook;
		repeat (reps) begin
			dial_ticks.push_back(t);
			ticks_made++;
		end
	endtask

	// Dialing traffic shaped by the current settings: mostly clean digits with
	// contact bounce, plus hang-ups, on-hook dialing and random noise.
	task automatic make_dialing(input int n_ticks);
		int stop_at;
		int kind;
		int pulses;
		int accept_len;
		int gap_len;
		stop_at = ticks_made + n_ticks;
		accept_len = (debounce_limit > 8) ? 10 : int'(debounce_limit) + 2;
		gap_len = (finish_limit > 60) ? 62 : int'(finish_limit) + 2;
		while (ticks_made < stop_at) begin
			kind = $urandom_range(99);
			if (kind < 5) begin
				put_ticks(1'b0, 1'b0, $urandom_range(1, 2));
				repeat ($urandom_range(0, 3)) begin
					put_ticks(1'($urandom_range(1)), 1'b0, $urandom_range(1, 3));
				end
				put_ticks(1'b0, 1'b1, $urandom_range(1, 3));
			end else if (kind < 10) begin
				repeat ($urandom_range(1, 6)) begin
					put_ticks(1'($urandom_range(1)), $urandom_range(99) < 80, 1);
				end
			end else begin
				kind = $urandom_range(99);
				if (kind < 55) begin
					pulses = $urandom_range(0, 5);
					if (pulses == 0) pulses = DIAL_BASE;
				end else if (kind < 96) begin
					pulses = $urandom_range(1, 10);
				end else begin
					pulses = $urandom_range(11, 34);
				end
				repeat (pulses) begin
					if ($urandom_range(99) < 20) begin
						put_ticks(1'b1, 1'b1, $urandom_range(1, accept_len - 1));
						put_ticks(1'b0, 1'b1, $urandom_range(1, accept_len - 1));
					end
					put_ticks(1'b1, 1'b1, accept_len + $urandom_range(2));
					put_ticks(1'b0, 1'b1, accept_len + $urandom_range(2));
				end
				put_ticks(1'b0, 1'b1, gap_len + $urandom_range(3));
			end
		end
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_FINISH) begin
			finish_limit = value;
		end else begin
			debounce_limit = value;
		end
	endtask

	// Waits until every item is sent and every result has come back.
	task automatic drain();
		@(negedge clk);
		while (dial_ticks.size() != 0 || in_valid || tick_results_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic run_phase(input logic [15:0] fin, input logic [15:0] deb,
			input int idle_pct, input int stall_in, input bit long_hold, input int n_ticks);
		write_reg(CFG_FINISH, fin);
		write_reg(CFG_DEBOUNCE, deb);
		@(negedge clk);
		send_idle_pct = idle_pct;
		stall_pct = stall_in;
		if (long_hold) hold_arm++;
		make_dialing(n_ticks);
		drain();
	endtask

	// Sender: offers queued tick items and predicts each accepted one.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				tick_results_due.push_back(decode_tick(dial_level, hook_level));
			end
			if (!in_valid || !in_stall) begin
				if (dial_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_tick = dial_ticks.pop_front();
					in_valid   <= 1'b1;
					dial_level <= next_tick.dial;
					hook_level <= next_tick.hook;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, started from the stimulus sequence.
	always @(posedge clk) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_seen <= 0;
		end else if (hold_seen != hold_arm) begin
			hold_seen <= hold_arm;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Receiver: stalls at random and checks every accepted result item.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
			if (out_valid && !out_stall) begin
				if (tick_results_due.size() == 0) begin
					$display("%0t: result item with none expected, event %0d digit %0d",
						$time, digit_event, digit);
					mismatch_count++;
				end else begin
					due_result = tick_results_due.pop_front();
					check_field("digit_event", due_result.digit_event, digit_event);
					check_field("digit", due_result.digit, digit);
					check_field("position", due_result.position, position);
					check_field("entry_done", due_result.entry_done, entry_done);
					check_field("minutes", due_result.minutes, minutes);
					check_field("seconds", due_result.seconds, seconds);
				end
			end
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		finish_limit = FINISH_RESET;
		debounce_limit = DEBOUNCE_RESET;
		raw_prev = 1'b0;
		level_kept = 1'b0;
		quiet_cnt = '0;
		pulse_cnt = '0;
		pend = 1'b0;
		pos_cnt = POS_MIN_TENS;
		for (int i = 0; i < 3; i++) digit_store[i] = '0;
		hook_down = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Slow dialing under the reset values of the registers.
		@(negedge clk);
		make_dialing(260);
		drain();

		// Directed: on-hook dialing is ignored, a one-pulse digit, a digit
		// that closes after hang-up, and a lift that clears the entry.
		write_reg(CFG_FINISH, 16'd1);
		write_reg(CFG_DEBOUNCE, 16'd0);
		@(negedge clk);
		put_ticks(1'b1, 1'b0, 1);
		put_ticks(1'b0, 1'b0, 1);
		put_ticks(1'b1, 1'b0, 2);
		put_ticks(1'b0, 1'b0, 1);
		put_ticks(1'b0, 1'b1, 2);
		put_ticks(1'b1, 1'b1, 2);
		put_ticks(1'b0, 1'b1, 3);
		put_ticks(1'b1, 1'b1, 2);
		put_ticks(1'b0, 1'b0, 3);
		put_ticks(1'b0, 1'b1, 2);
		put_ticks(1'b1, 1'b1, 2);
		put_ticks(1'b0, 1'b1, 3);
		drain();

		run_phase(16'd4, 16'd1, 0, 0, 1'b0, 160);
		run_phase(16'd6, 16'd2, 57, 0, 1'b0, 160);
		run_phase(16'd3, 16'd0, 0, 57, 1'b1, 160);
		run_phase(16'd0, 16'd0, 23, 23, 1'b0, 120);

		// A digit that never closes, with the pulse count driven past saturation.
		write_reg(CFG_FINISH, 16'hFFFF);
		write_reg(CFG_DEBOUNCE, 16'd1);
		@(negedge clk);
		send_idle_pct = 0;
		stall_pct = 0;
		repeat (34) begin
			put_ticks(1'b1, 1'b1, 3);
			put_ticks(1'b0, 1'b1, 3);
		end
		make_dialing(40);
		drain();

		// The saturated digit closes; with the largest debounce nothing counts.
		run_phase(16'd2, 16'hFFFF, 23, 23, 1'b0, 60);
		run_phase(16'd5, 16'd3, 23, 23, 1'b0, 100);

		if (mismatch_count == 0 && tick_results_due.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
